// ===== sv/gbcs_pkg.sv =====
package gbcs_pkg;

    localparam int MAX_DIMENSION_DEF = 2048;

    localparam int DIM_CFG_W = 12;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COLOR_LIMIT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_SPEED = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TURN_STEER = 3'd4;

    localparam logic [DIM_CFG_W-1:0] RST_IMAGE_WIDTH = 12'd640;
    localparam logic [DIM_CFG_W-1:0] RST_IMAGE_HEIGHT = 12'd480;
    localparam logic [7:0] RST_COLOR_LIMIT = 8'd100;
    localparam logic signed [15:0] RST_DRIVE_SPEED = 16'sd5;
    localparam logic [14:0] RST_TURN_STEER = 15'd10;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } t_in;

    typedef struct packed {
        logic [7:0]         masked_blue;
        logic [7:0]         masked_green;
        logic [7:0]         masked_red;
        logic               frame_done;
        logic               target_found;
        logic [10:0]        center_x;
        logic [10:0]        center_y;
        logic [22:0]        kept_count;
        logic signed [15:0] steer;
        logic signed [15:0] speed;
    } t_out;

    typedef enum logic [1:0] {
        ST_RUN,
        ST_DIV,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic ready;
        logic accept;
        logic div_start;
        logic pix_out;
        logic frame_out;
    } t_cmd;

    typedef struct packed {
        logic last;
        logic div_busy;
        logic out_busy;
    } t_status;

endpackage

// ===== sv/gbcs_div.sv =====
module gbcs_div #(
    parameter int CW = 11,
    parameter int KW = 23,
    parameter int SW = 34
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [SW-1:0] i_dividend,
    input  logic [KW-1:0] i_divisor,
    output logic          o_busy,
    output logic [CW-1:0] o_quot
);

    localparam int CNTW = $clog2(CW + 1);

    logic            r_busy, n_busy;
    logic [CNTW-1:0] r_cnt, n_cnt;
    logic [SW-1:0]   r_rem, n_rem;
    logic [SW-1:0]   r_dsr, n_dsr;
    logic [CW-1:0]   r_quot, n_quot;
    logic            ge;
    logic [CW:0]     quot_shift;

    always_comb begin
        ge = r_rem >= r_dsr;
        quot_shift = {r_quot, ge};
        n_busy = r_busy;
        n_cnt = r_cnt;
        n_rem = r_rem;
        n_dsr = r_dsr;
        n_quot = r_quot;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt = CNTW'(CW - 1);
            n_rem = i_dividend;
            n_dsr = SW'(i_divisor) << (CW - 1);
            n_quot = '0;
        end else if (r_busy) begin
            n_rem = ge ? r_rem - r_dsr : r_rem;
            n_dsr = r_dsr >> 1;
            n_quot = quot_shift[CW-1:0];
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == '0) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_dsr <= n_dsr;
        r_quot <= n_quot;
    end

    assign o_busy = r_busy;
    assign o_quot = r_quot;

endmodule

// ===== sv/gbcs_dp.sv =====
module gbcs_dp #(
    parameter int MAX_DIMENSION = gbcs_pkg::MAX_DIMENSION_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  gbcs_pkg::t_cmd                  i_cmd,
    output gbcs_pkg::t_status               o_status,
    input  gbcs_pkg::t_in                   i_in_data,
    input  logic                            i_out_stall,
    output logic                            o_out_valid,
    output gbcs_pkg::t_out                  o_out_data,
    input  logic                            i_cfg_we,
    input  logic [gbcs_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [gbcs_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int CW = $clog2(MAX_DIMENSION);
    localparam int KW = 2 * CW + 1;
    localparam int SW = KW + CW;
    localparam int DW = gbcs_pkg::DIM_CFG_W;
    localparam logic [DW:0] MAXV = (DW + 1)'(MAX_DIMENSION);

    logic [DW-1:0]      r_img_w, r_img_h;
    logic [7:0]         r_limit;
    logic signed [15:0] r_speed;
    logic [14:0]        r_turn;

    logic [CW-1:0] r_col, r_row;
    logic [SW-1:0] r_col_sum, n_col_sum, r_row_sum, n_row_sum;
    logic [KW-1:0] r_kept, n_kept, r_frame_count;
    gbcs_pkg::t_in r_pix;
    logic          r_out_valid, n_out_valid;
    gbcs_pkg::t_out r_out, n_out;

    logic [DW:0]   w_clamp, h_clamp, w_m1_full, h_m1_full, half_full;
    logic [CW-1:0] w_m1, h_m1, half;
    logic          kept, row_end, last, found;
    gbcs_pkg::t_in masked, frame_pix;
    logic [CW-1:0] quot_x, quot_y;
    logic          busy_x, busy_y;
    logic [CW+10:0] cx_ext, cy_ext;
    logic [KW+22:0] count_ext;
    logic signed [15:0] turn_pos;

    function automatic logic [DW:0] clamp_dim(input logic [DW-1:0] v);
        logic [DW:0] vx;
        vx = {1'b0, v};
        if (v == '0) begin
            return (DW + 1)'(1);
        end else if (vx > MAXV) begin
            return MAXV;
        end
        return vx;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_w <= gbcs_pkg::RST_IMAGE_WIDTH;
            r_img_h <= gbcs_pkg::RST_IMAGE_HEIGHT;
            r_limit <= gbcs_pkg::RST_COLOR_LIMIT;
            r_speed <= gbcs_pkg::RST_DRIVE_SPEED;
            r_turn <= gbcs_pkg::RST_TURN_STEER;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                gbcs_pkg::CFG_IMAGE_WIDTH: r_img_w <= i_cfg_data[DW-1:0];
                gbcs_pkg::CFG_IMAGE_HEIGHT: r_img_h <= i_cfg_data[DW-1:0];
                gbcs_pkg::CFG_COLOR_LIMIT: r_limit <= i_cfg_data[7:0];
                gbcs_pkg::CFG_DRIVE_SPEED: r_speed <= i_cfg_data;
                gbcs_pkg::CFG_TURN_STEER: r_turn <= i_cfg_data[14:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        w_clamp = clamp_dim(r_img_w);
        h_clamp = clamp_dim(r_img_h);
        w_m1_full = w_clamp - 1'b1;
        h_m1_full = h_clamp - 1'b1;
        half_full = w_clamp >> 1;
        w_m1 = w_m1_full[CW-1:0];
        h_m1 = h_m1_full[CW-1:0];
        half = half_full[CW-1:0];

        kept = (i_in_data.green > i_in_data.blue) && (i_in_data.green > i_in_data.red)
            && !((i_in_data.blue > r_limit) && (i_in_data.red > r_limit));
        masked = kept ? i_in_data : '0;
        row_end = r_col >= w_m1;
        last = row_end && (r_row >= h_m1);

        n_col_sum = r_col_sum + (kept ? SW'(r_col) : '0);
        n_row_sum = r_row_sum + (kept ? SW'(r_row) : '0);
        n_kept = r_kept + (kept ? KW'(1) : '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
            r_col_sum <= '0;
            r_row_sum <= '0;
            r_kept <= '0;
        end else if (i_cmd.accept) begin
            if (last) begin
                r_col <= '0;
                r_row <= '0;
                r_col_sum <= '0;
                r_row_sum <= '0;
                r_kept <= '0;
            end else begin
                r_col <= row_end ? '0 : r_col + 1'b1;
                r_row <= row_end ? r_row + 1'b1 : r_row;
                r_col_sum <= n_col_sum;
                r_row_sum <= n_row_sum;
                r_kept <= n_kept;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_pix <= masked;
            r_frame_count <= n_kept;
        end
    end

    gbcs_div #(.CW(CW), .KW(KW), .SW(SW)) u_div_x (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (i_cmd.div_start),
        .i_dividend(n_col_sum),
        .i_divisor (n_kept),
        .o_busy    (busy_x),
        .o_quot    (quot_x)
    );

    gbcs_div #(.CW(CW), .KW(KW), .SW(SW)) u_div_y (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (i_cmd.div_start),
        .i_dividend(n_row_sum),
        .i_divisor (n_kept),
        .o_busy    (busy_y),
        .o_quot    (quot_y)
    );

    always_comb begin
        found = r_frame_count != '0;
        cx_ext = {11'b0, quot_x};
        cy_ext = {11'b0, quot_y};
        count_ext = {23'b0, r_frame_count};
        turn_pos = {1'b0, r_turn};
        frame_pix = r_pix;

        n_out_valid = r_out_valid;
        n_out = r_out;
        if (i_cmd.pix_out) begin
            n_out_valid = 1'b1;
            n_out = '0;
            n_out.masked_blue = masked.blue;
            n_out.masked_green = masked.green;
            n_out.masked_red = masked.red;
        end else if (i_cmd.frame_out) begin
            n_out_valid = 1'b1;
            n_out = '0;
            n_out.masked_blue = frame_pix.blue;
            n_out.masked_green = frame_pix.green;
            n_out.masked_red = frame_pix.red;
            n_out.frame_done = 1'b1;
            if (found) begin
                n_out.target_found = 1'b1;
                n_out.center_x = cx_ext[10:0];
                n_out.center_y = cy_ext[10:0];
                n_out.kept_count = count_ext[22:0];
                n_out.speed = r_speed;
                if (quot_x < half) begin
                    n_out.steer = turn_pos;
                end else if (quot_x > half) begin
                    n_out.steer = -turn_pos;
                end
            end
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_status.last = last;
    assign o_status.div_busy = busy_x | busy_y;
    assign o_status.out_busy = r_out_valid & i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data = r_out;

endmodule

// ===== sv/gbcs_ctrl.sv =====
module gbcs_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  gbcs_pkg::t_status i_status,
    output gbcs_pkg::t_cmd    o_cmd
);

    gbcs_pkg::t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        case (r_state)
            gbcs_pkg::ST_RUN: begin
                if (i_in_valid && !i_status.out_busy && i_status.last) begin
                    n_state = gbcs_pkg::ST_DIV;
                end
            end
            gbcs_pkg::ST_DIV: begin
                if (!i_status.div_busy) begin
                    n_state = gbcs_pkg::ST_OUT;
                end
            end
            gbcs_pkg::ST_OUT: begin
                if (!i_status.out_busy) begin
                    n_state = gbcs_pkg::ST_RUN;
                end
            end
            default: n_state = gbcs_pkg::ST_RUN;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        case (r_state)
            gbcs_pkg::ST_RUN: begin
                o_cmd.ready = !i_status.out_busy;
                o_cmd.accept = o_cmd.ready && i_in_valid;
                o_cmd.div_start = o_cmd.accept && i_status.last;
                o_cmd.pix_out = o_cmd.accept && !i_status.last;
            end
            gbcs_pkg::ST_OUT: begin
                o_cmd.frame_out = !i_status.out_busy;
            end
            default: o_cmd = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gbcs_pkg::ST_RUN;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== sv/green_blob_centroid_steer.sv =====
// Green blob tracker for a BGR pixel stream in raster order. Each accepted pixel gives one
// result: the pixel itself if green dominates and blue and red are not both above the color
// limit, otherwise zero. Ordinary pixels are taken while the result register is not blocked.
// The last pixel of a frame starts two shift-subtract dividers that form the centroid one
// quotient bit per cycle, and no further request is taken until the frame result is loaded.
// That result carries the centroid, the kept count, the speed and a steer command taken from
// the centroid column against half the image width; with no kept pixels the frame fields
// other than frame_done are zero.
module green_blob_centroid_steer #(
    parameter int MAX_DIMENSION = gbcs_pkg::MAX_DIMENSION_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  gbcs_pkg::t_in                   i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output gbcs_pkg::t_out                  o_out_data,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [gbcs_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [gbcs_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    gbcs_pkg::t_cmd    cmd;
    gbcs_pkg::t_status status;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall = !cmd.ready;

    gbcs_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .i_status  (status),
        .o_cmd     (cmd)
    );

    gbcs_dp #(.MAX_DIMENSION(MAX_DIMENSION)) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_status   (status),
        .i_in_data  (i_in_data),
        .i_out_stall(i_out_stall),
        .o_out_valid(o_out_valid),
        .o_out_data (o_out_data),
        .i_cfg_we   (i_cfg_valid && o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

`ifndef SYNTHESIS
    a_no_accept_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |-> o_in_stall)
        else $error("Request taken while the result register is blocked.");

    a_no_accept_while_dividing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        status.div_busy |-> o_in_stall)
        else $error("Request taken while the centroid division runs.");

    a_no_target_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.target_found) |->
        (o_out_data.steer == '0 && o_out_data.speed == '0 && o_out_data.kept_count == '0))
        else $error("Frame fields set without a target.");

    a_frame_after_division: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.frame_out |-> !status.div_busy)
        else $error("Frame result loaded before the division finished.");
`endif

endmodule
